FILE: design/msbbp_pkg.sv
// Package for the MSB-first bit stream packer/unpacker core.
// Holds the transfer payload structs, opcode and state enums, and sizing constants.
// No dependencies; used by every file in this folder.
`default_nettype none

package msbbp_pkg;

    // Default store size in bytes.
    localparam int STORE_BYTES_DEF = 256;

    // Field widths.
    localparam int STREAM_W = 9;
    localparam int CURSOR_W = 12;
    localparam int COUNT_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int BYTE_W   = 8;

    // Reset value of the stream size register.
    localparam logic [STREAM_W-1:0] STREAM_BYTES_RST = 9'd256;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REWIND = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MODIFY,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Input transfer payload.
    typedef struct packed {
        opcode_t              opcode;
        logic [COUNT_W-1:0]   bit_count;
        logic [VALUE_W-1:0]   write_value;
    } in_item_t;

    // Result transfer payload.
    typedef struct packed {
        logic [BYTE_W-1:0]    read_data;
        logic                 at_end;
        logic [CURSOR_W-1:0]  bit_position;
    } out_item_t;

endpackage

`default_nettype wire

FILE: design/msb_first_bit_packer_unpacker_core.sv
// Flow: a read or write with a nonzero length, taken while the end flag is clear, runs through
// ST_MODIFY byte by byte (a single step when it finds the cursor at the end), then ST_DONE,
// which loads the result and raises m_valid once the output is free; rewind, zero-length
// and end-flag items go straight to ST_DONE; clear first sweeps the used bytes in ST_CLEAR,
// if there are any. s_ready is high only in ST_IDLE, so items are worked one at a time.
// Reset: synchronous active-low aresetn; afterwards the store is zeroed by a sweep during
// which s_ready stays low. Configuration writes are always taken. Depends on msbbp_pkg.
`default_nettype none

module msb_first_bit_packer_unpacker_core #(
    parameter int STORE_BYTES = msbbp_pkg::STORE_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  msbbp_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output msbbp_pkg::out_item_t                m_data,
    input  logic                                cfg_we,
    input  logic [msbbp_pkg::STREAM_W-1:0]      cfg_wdata
);

    localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW     = msbbp_pkg::CURSOR_W;
    localparam int BW     = msbbp_pkg::BYTE_W;

    // Byte store with one write port and one registered read port.
    logic [BW-1:0] mem [STORE_BYTES];
    logic [BW-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BW-1:0]     mem_wdata;
    logic [ADDR_W-1:0] rd_addr;

    // Control state.
    msbbp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic              end_reg, end_next;
    logic [msbbp_pkg::STREAM_W-1:0] stream_reg, stream_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] clr_last_reg, clr_last_next;
    logic              m_valid_reg, m_valid_next;

    // Payload state.
    logic [msbbp_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic [msbbp_pkg::VALUE_W-1:0] wval_reg, wval_next;
    logic                          is_wr_reg, is_wr_next;
    logic [BW-1:0]                 rd_reg, rd_next;
    msbbp_pkg::out_item_t          m_data_reg, m_data_next;

    // Derived control terms.
    logic                          in_acc;
    logic                          out_free;
    logic                          start_xfer;
    logic                          clr_done;
    logic [msbbp_pkg::STREAM_W-1:0] used_bytes;
    logic [CW-1:0]                 lim;
    logic                          at_lim;
    logic [2:0]                    off;
    logic [3:0]                    avail;
    logic [3:0]                    take_a;
    logic [CW-1:0]                 room;
    logic [3:0]                    k;
    logic [CW-1:0]                 cur_step;
    logic [msbbp_pkg::COUNT_W-1:0] rem_step;
    logic                          xfer_last;
    logic [ADDR_W-1:0]             cur_addr;
    logic [ADDR_W-1:0]             step_addr;

    // Digit datapath terms.
    logic [71:0]                   ext;
    logic [BW-1:0]                 win;
    logic [BW-1:0]                 kmask;
    logic [BW-1:0]                 wr_byte;
    logic [BW-1:0]                 shifted;
    logic [BW-1:0]                 taken;
    logic [2*BW-1:0]               rd_shift;
    logic [BW-1:0]                 rd_new;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == msbbp_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Stream end: the stream size is clamped to the store size.
    assign used_bytes = (32'(stream_reg) > STORE_BYTES) ? msbbp_pkg::STREAM_W'(STORE_BYTES)
                                                         : stream_reg;
    assign lim        = {used_bytes, 3'b000};
    assign at_lim     = (cursor_reg >= lim);

    // Chunk size: limited by the bits left, the rest of the byte and the room to the end.
    assign off      = cursor_reg[2:0];
    assign avail    = 4'd8 - {1'b0, off};
    assign take_a   = ({2'b00, avail} > rem_reg) ? rem_reg[3:0] : avail;
    assign room     = lim - cursor_reg;
    assign k        = (room < CW'(take_a)) ? room[3:0] : take_a;
    assign cur_step = cursor_reg + CW'(k);
    assign rem_step = rem_reg - msbbp_pkg::COUNT_W'(k);
    assign xfer_last = (rem_step == '0) || (cur_step >= lim);

    assign cur_addr  = ADDR_W'(cursor_reg[CW-1:3]);
    assign step_addr = ADDR_W'(cur_step[CW-1:3]);

    assign start_xfer = !end_reg && (s_data.bit_count != '0);
    assign clr_done   = (clr_cnt_reg == clr_last_reg);

    // Write digit: the next eight stream bits of the zero-extended value, top aligned.
    assign ext     = {32'b0, wval_reg, 8'b0};
    assign win     = ext[rem_reg +: 8];
    assign kmask   = ~(8'hFF >> k);
    assign wr_byte = rdata_reg | ((win & kmask) >> off);

    // Read digit: k bits from the current byte shifted into the result.
    assign shifted  = rdata_reg << off;
    assign taken    = shifted >> (4'd8 - k);
    assign rd_shift = {8'b0, rd_reg} << k;
    assign rd_new   = rd_shift[BW-1:0] | taken;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msbbp_pkg::ST_INIT: begin
                if (clr_done) begin
                    state_next = msbbp_pkg::ST_IDLE;
                end
            end
            msbbp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (s_data.opcode)
                        msbbp_pkg::OP_READ,
                        msbbp_pkg::OP_WRITE: begin
                            state_next = start_xfer ? msbbp_pkg::ST_MODIFY
                                                    : msbbp_pkg::ST_DONE;
                        end
                        msbbp_pkg::OP_CLEAR: begin
                            state_next = (used_bytes != '0) ? msbbp_pkg::ST_CLEAR
                                                            : msbbp_pkg::ST_DONE;
                        end
                        default: begin
                            state_next = msbbp_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            msbbp_pkg::ST_MODIFY: begin
                if (at_lim || xfer_last) begin
                    state_next = msbbp_pkg::ST_DONE;
                end
            end
            msbbp_pkg::ST_CLEAR: begin
                if (clr_done) begin
                    state_next = msbbp_pkg::ST_DONE;
                end
            end
            msbbp_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = msbbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = msbbp_pkg::ST_INIT;
            end
        endcase
    end

    // Datapath, memory port and result register.
    always_comb begin
        cursor_next   = cursor_reg;
        end_next      = end_reg;
        stream_next   = cfg_we ? cfg_wdata : stream_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_last_next = clr_last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rem_next      = rem_reg;
        wval_next     = wval_reg;
        is_wr_next    = is_wr_reg;
        rd_next       = rd_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_addr;
        mem_wdata     = wr_byte;
        rd_addr       = cur_addr;
        case (state_reg)
            msbbp_pkg::ST_INIT,
            msbbp_pkg::ST_CLEAR: begin
                // Zero one byte per cycle.
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_done && (state_reg == msbbp_pkg::ST_CLEAR)) begin
                    cursor_next = '0;
                    end_next    = 1'b0;
                end
            end
            msbbp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    rd_next    = '0;
                    rem_next   = s_data.bit_count;
                    wval_next  = s_data.write_value;
                    is_wr_next = (s_data.opcode == msbbp_pkg::OP_WRITE);
                    case (s_data.opcode)
                        msbbp_pkg::OP_READ: begin
                            // A zero-length read still notices the stream end.
                            if (!end_reg && at_lim) begin
                                end_next = 1'b1;
                            end
                        end
                        msbbp_pkg::OP_WRITE: begin
                            end_next = end_reg;
                        end
                        msbbp_pkg::OP_CLEAR: begin
                            clr_cnt_next  = '0;
                            clr_last_next = ADDR_W'(used_bytes - 1'b1);
                            if (used_bytes == '0) begin
                                cursor_next = '0;
                                end_next    = 1'b0;
                            end
                        end
                        default: begin
                            cursor_next = '0;
                            end_next    = 1'b0;
                        end
                    endcase
                end
            end
            msbbp_pkg::ST_MODIFY: begin
                // One byte per cycle; the next byte is fetched while this one is written.
                if (at_lim) begin
                    end_next = 1'b1;
                end else begin
                    mem_we      = is_wr_reg;
                    rd_next     = is_wr_reg ? rd_reg : rd_new;
                    cursor_next = cur_step;
                    rem_next    = rem_step;
                    end_next    = (cur_step >= lim);
                    rd_addr     = step_addr;
                end
            end
            msbbp_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.read_data    = rd_reg;
                    m_data_next.at_end       = end_reg;
                    m_data_next.bit_position = cursor_reg;
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= msbbp_pkg::ST_INIT;
            cursor_reg   <= '0;
            end_reg      <= 1'b0;
            stream_reg   <= msbbp_pkg::STREAM_BYTES_RST;
            clr_cnt_reg  <= '0;
            clr_last_reg <= ADDR_W'(STORE_BYTES - 1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            end_reg      <= end_next;
            stream_reg   <= stream_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_last_reg <= clr_last_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        wval_reg   <= wval_next;
        is_wr_reg  <= is_wr_next;
        rd_reg     <= rd_next;
        m_data_reg <= m_data_next;
    end

    // Byte store.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/msbbp_checker.sv
// Port-level checker for the MSB-first bit stream packer/unpacker core.
// Tracks outstanding transfers and is bound to the top level. Depends on msbbp_pkg.
`default_nettype none

module msbbp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input msbbp_pkg::out_item_t           m_data
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg, pend_next;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Items accepted whose results are not yet delivered.
    always_comb begin
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Reset starts the store sweep with both channels quiet.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!s_ready && !m_valid))
        else $error("channels active right after reset");

    // A waiting result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // No result is delivered without an accepted item behind it.
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (pend_reg != 2'd0))
        else $error("result without an accepted item");

    // At most one item in work and one result waiting.
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many items outstanding");

    // Items are worked one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input taken while an item is in work");

endmodule

bind msb_first_bit_packer_unpacker_core msbbp_checker u_msbbp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

`default_nettype wire
